FILE: hw/rtl/mfre_pkg.sv
// ----------------------------------------------------------------------------
// mfre_pkg
// Shared constants for the monochrome framebuffer rectangle engine: command
// codes, page geometry and store address widths.
// ----------------------------------------------------------------------------
package mfre_pkg;

   // Command codes carried on the request tuser field
   localparam logic [2:0] FUNC_SET        = 3'd0;
   localparam logic [2:0] FUNC_CLEAR      = 3'd1;
   localparam logic [2:0] FUNC_INVERT     = 3'd2;
   localparam logic [2:0] FUNC_CLEAR_PAGE = 3'd3;
   localparam logic [2:0] FUNC_COPY_PAGE  = 3'd4;
   localparam logic [2:0] FUNC_READ       = 3'd5;

   // Store geometry
   localparam int PAGES      = 8;
   localparam int PAGE_BYTES = 1024;
   localparam int OFF_W      = 10;
   localparam int PG_W       = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int MEM_DEPTH  = PAGES * PAGE_BYTES;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);

   // Byte column and row ranges of one 128x64 page
   localparam logic [3:0] COL_LAST = 4'd15;
   localparam logic [5:0] ROW_LAST = 6'd63;

endpackage

FILE: hw/rtl/mono_framebuffer_rect_engine.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_rect_engine
// Multi-page 1-bit 128x64 framebuffer with rectangle set/clear/invert, page
// clear, page copy and single-byte read commands.
// ----------------------------------------------------------------------------
// After reset the engine sweeps the whole store to zero, one byte a cycle,
// and takes no request until that is done. Each request then runs alone and
// gives one response. Rectangle and page copy commands stream one byte a
// cycle through a read-modify-write pipe on the single store write port.
// Page clears, byte reads and empty or out-of-range commands also end in the
// completion state, which holds while the response side stalls. The request
// channel is ready only while the engine is idle; the response register lets
// a finished result wait while the next request is taken.
// ----------------------------------------------------------------------------
module mono_framebuffer_rect_engine (
   input  logic        clock,
   input  logic        reset,
   // Request: tdata = page[2:0], source_page[5:3], x_left[12:6],
   //          x_right[19:13], y_top[25:20], y_bottom[31:26],
   //          byte_address[41:32], zero fill [47:42]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [2:0]  req_tuser,   // func[2:0]
   // Response: tdata = read_data[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic [2:0]  rsp_tuser    // done_func[2:0]
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SWEEP = 3'd2;
   localparam logic [2:0] S_FILL  = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam logic [mfre_pkg::MEM_AW-1:0] CLR_LAST =
      mfre_pkg::MEM_AW'(mfre_pkg::MEM_DEPTH - 1);

   // Request fields
   logic [2:0] req_func;
   logic [2:0] req_page;
   logic [2:0] req_src;
   logic [6:0] req_xl;
   logic [6:0] req_xr;
   logic [5:0] req_yt;
   logic [5:0] req_yb;
   logic [9:0] req_addr;
   logic       page_ok;
   logic       src_ok;

   assign req_func = req_tuser;
   assign req_page = req_tdata[2:0];
   assign req_src  = req_tdata[5:3];
   assign req_xl   = req_tdata[12:6];
   assign req_xr   = req_tdata[19:13];
   assign req_yt   = req_tdata[25:20];
   assign req_yb   = req_tdata[31:26];
   assign req_addr = req_tdata[41:32];
   assign page_ok  = int'(req_page) < mfre_pkg::PAGES;
   assign src_ok   = int'(req_src) < mfre_pkg::PAGES;

   // Sequencer and command registers
   logic [2:0]                   state_ff, state_in;
   logic [mfre_pkg::MEM_AW-1:0]  clr_ff, clr_in;
   logic [2:0]                   func_ff, func_in;
   logic [mfre_pkg::PG_W-1:0]    page_ff, page_in;
   logic [mfre_pkg::PG_W-1:0]    src_ff, src_in;
   logic [2:0]                   xl3_ff, xl3_in;
   logic [2:0]                   xr3_ff, xr3_in;
   logic [3:0]                   first_ff, first_in;
   logic [3:0]                   last_ff, last_in;
   logic [5:0]                   yb_ff, yb_in;
   logic [3:0]                   col_ff, col_in;
   logic [5:0]                   y_ff, y_in;
   logic [9:0]                   byte_ff, byte_in;
   logic [7:0]                   res_data_ff, res_data_in;

   // Write-back stage of the read-modify-write pipe
   logic                         wb_valid_ff, wb_valid_in;
   logic [mfre_pkg::MEM_AW-1:0]  wb_addr_ff, wb_addr_in;
   logic [7:0]                   wb_mask_ff, wb_mask_in;

   // Response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [7:0]                   rsp_data_ff, rsp_data_in;
   logic [2:0]                   rsp_func_ff, rsp_func_in;

   // Store ports
   logic                         ram_we;
   logic [mfre_pkg::MEM_AW-1:0]  ram_waddr;
   logic [7:0]                   ram_wdata;
   logic [mfre_pkg::MEM_AW-1:0]  ram_raddr;
   logic [7:0]                   ram_rdata;

   // Sweep position helpers
   logic [9:0]                   off;
   logic                         sweep_last;
   logic [7:0]                   mask;
   logic [7:0]                   modified;

   assign off        = ~{col_ff, y_ff};
   assign sweep_last = (col_ff == last_ff) && (y_ff == yb_ff);

   // Build the edge mask of the current byte column
   always_comb begin
      mask = 8'hff;
      if (col_ff == first_ff) begin
         mask = mask & (8'hff >> xl3_ff);
      end
      if (col_ff == last_ff) begin
         mask = mask & ~(8'h7f >> xr3_ff);
      end
   end

   // Shared modify unit of the write-back stage
   always_comb begin
      case (func_ff)
         mfre_pkg::FUNC_SET:    modified = ram_rdata | wb_mask_ff;
         mfre_pkg::FUNC_CLEAR:  modified = ram_rdata & ~wb_mask_ff;
         mfre_pkg::FUNC_INVERT: modified = ram_rdata ^ wb_mask_ff;
         default:               modified = ram_rdata;
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      func_in      = func_ff;
      page_in      = page_ff;
      src_in       = src_ff;
      xl3_in       = xl3_ff;
      xr3_in       = xr3_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      yb_in        = yb_ff;
      col_in       = col_ff;
      y_in         = y_ff;
      byte_in      = byte_ff;
      res_data_in  = res_data_ff;
      wb_valid_in  = 1'b0;
      wb_addr_in   = wb_addr_ff;
      wb_mask_in   = wb_mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_func_in  = rsp_func_ff;
      ram_we       = wb_valid_ff;
      ram_waddr    = wb_addr_ff;
      ram_wdata    = modified;
      ram_raddr    = mfre_pkg::MEM_AW'({page_ff, off});

      case (state_ff)
         S_CLEAR: begin
            // Zero the store after reset
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 8'h00;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               // Latch the request and pick the sweep ranges
               func_in     = req_func;
               page_in     = mfre_pkg::PG_W'(req_page);
               src_in      = mfre_pkg::PG_W'(req_src);
               xl3_in      = req_xl[2:0];
               xr3_in      = req_xr[2:0];
               byte_in     = req_addr;
               res_data_in = 8'h00;
               first_in    = 4'd0;
               last_in     = mfre_pkg::COL_LAST;
               yb_in       = mfre_pkg::ROW_LAST;
               col_in      = 4'd0;
               y_in        = 6'd0;
               state_in    = S_DONE;
               case (req_func)
                  mfre_pkg::FUNC_SET, mfre_pkg::FUNC_CLEAR, mfre_pkg::FUNC_INVERT: begin
                     first_in = req_xl[6:3];
                     last_in  = req_xr[6:3];
                     yb_in    = req_yb;
                     col_in   = req_xl[6:3];
                     y_in     = req_yt;
                     if (page_ok && (req_xl <= req_xr) && (req_yt <= req_yb)) begin
                        state_in = S_SWEEP;
                     end
                  end
                  mfre_pkg::FUNC_CLEAR_PAGE: begin
                     if (page_ok) begin
                        state_in = S_FILL;
                     end
                  end
                  mfre_pkg::FUNC_COPY_PAGE: begin
                     if (page_ok && src_ok && (req_src != req_page)) begin
                        state_in = S_SWEEP;
                     end
                  end
                  mfre_pkg::FUNC_READ: begin
                     if (page_ok) begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            // Issue one read a cycle; write back the modified byte next cycle
            if (func_ff == mfre_pkg::FUNC_COPY_PAGE) begin
               ram_raddr = mfre_pkg::MEM_AW'({src_ff, off});
            end
            wb_valid_in = 1'b1;
            wb_addr_in  = mfre_pkg::MEM_AW'({page_ff, off});
            wb_mask_in  = mask;
            if (col_ff == last_ff) begin
               col_in = first_ff;
               y_in   = y_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (sweep_last) begin
               state_in = S_DRAIN;
            end
         end
         S_FILL: begin
            // Zero one byte of the page a cycle
            ram_we    = 1'b1;
            ram_waddr = mfre_pkg::MEM_AW'({page_ff, off});
            ram_wdata = 8'h00;
            if (col_ff == last_ff) begin
               col_in = first_ff;
               y_in   = y_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            ram_raddr = mfre_pkg::MEM_AW'({page_ff, byte_ff});
            state_in  = S_DRAIN;
         end
         S_DRAIN: begin
            // Last write-back lands here; read data is valid here
            if (func_ff == mfre_pkg::FUNC_READ) begin
               res_data_in = ram_rdata;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_func_in  = func_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      page_ff     <= page_in;
      src_ff      <= src_in;
      xl3_ff      <= xl3_in;
      xr3_ff      <= xr3_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      yb_ff       <= yb_in;
      col_ff      <= col_in;
      y_ff        <= y_in;
      byte_ff     <= byte_in;
      res_data_ff <= res_data_in;
      wb_addr_ff  <= wb_addr_in;
      wb_mask_ff  <= wb_mask_in;
      rsp_data_ff <= rsp_data_in;
      rsp_func_ff <= rsp_func_in;
   end

   // Page store
   mfre_ram #(
      .WIDTH (8),
      .DEPTH (mfre_pkg::MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_func_ff;

   // The write-back stage never competes with the direct zeroing writes
   a_wb_port_free: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> !(state_ff == S_CLEAR || state_ff == S_FILL))
      else $error("write-back collides with a zeroing write");

   // A response is only raised from the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside completion");

   // Only a byte read returns data
   a_data_only_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_func_ff != mfre_pkg::FUNC_READ) |-> rsp_data_ff == 8'h00)
      else $error("non-read response carries data");

   // The column counter stays inside the span while sweeping
   a_col_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP || state_ff == S_FILL) |->
         (col_ff >= first_ff && col_ff <= last_ff))
      else $error("column counter outside span");

endmodule

FILE: hw/rtl/mfre_ram.sv
// ----------------------------------------------------------------------------
// mfre_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mfre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
